// ===== rtl/tcg_pkg.sv =====
package tcg_pkg;

   // input opcodes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // control characters
   localparam logic [15:0] CODE_NEWLINE = 16'd10;
   localparam logic [15:0] CODE_CR      = 16'd13;
   localparam logic [15:0] NARROW_MAX   = 16'h00ff;

   // result kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_GLYPH  = 2'd0;
   localparam kind_type KIND_SCROLL = 2'd1;
   localparam kind_type KIND_CLEAR  = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FORE_COLOR    = 2'd2;
   localparam logic [1:0] CSR_BACK_COLOR    = 2'd3;

   localparam logic [4:0]  WIDTH_NARROW = 5'd8;
   localparam logic [4:0]  WIDTH_WIDE   = 5'd16;
   localparam logic [4:0]  LINE_HEIGHT  = 5'd16;
   localparam logic [3:0]  LAST_ROW     = 4'd15;
   localparam logic [12:0] ROW_MAX      = 13'h1fff;
   localparam logic [11:0] COL_MAX      = 12'hfff;

   // one pending result on its way to the output
   typedef struct packed {
      kind_type    kind;
      logic [11:0] pixel_x;
      logic [12:0] pixel_y;
      logic        wide;
      logic        glyph_ok;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic        en;
      logic [15:0] code;
      logic [3:0]  row;
   } rdreq_type;

   typedef struct packed {
      logic        en;
      logic [16:0] addr;
      logic [7:0]  data;
   } wrreq_type;

   function automatic logic [12:0] row_add(input logic [12:0] row, input logic [4:0] d);
      logic [13:0] s;
      s = {1'b0, row} + {9'b0, d};
      return s[13] ? ROW_MAX : s[12:0];
   endfunction

   // MSB-leftmost font byte to LSB-leftmost mask
   function automatic logic [7:0] flip8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7 - i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/tcg_ifs.sv =====
interface tcg_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] char_code;
   logic [16:0] font_address;
   logic [7:0]  font_byte;

   modport source (output valid, opcode, char_code, font_address, font_byte, input ready);
   modport sink (input valid, opcode, char_code, font_address, font_byte, output ready);
endinterface

interface tcg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] pixel_x;
   logic [12:0] pixel_y;
   logic [4:0]  pixel_count;
   logic [15:0] row_mask;
   logic [31:0] fore_color;
   logic [31:0] back_color;
   logic        last;

   modport source (output valid, kind, pixel_x, pixel_y, pixel_count, row_mask, fore_color,
                   back_color, last, input ready);
   modport sink (input valid, kind, pixel_x, pixel_y, pixel_count, row_mask, fore_color,
                 back_color, last, output ready);
endinterface

// ===== rtl/text_console_glyph_renderer_core.sv =====
// Text console glyph renderer. Each request transfer either loads one font byte
// (opcode 1, byte address code*32 + row*2 + half, MSB leftmost) or puts one
// character (opcode 0). Newline moves the cursor down 16 rows to column 0,
// carriage return moves it back 8 pixels stopping at 0; neither gives a result.
// Any other code yields an optional scroll (kind 1) or clear (kind 2) command
// when the cursor is at or below screen_height, wraps the line if the glyph
// does not fit in screen_width, then 16 glyph rows (kind 0), the last one
// flagged. Codes up to 255 are 8 pixels wide, others 16. Codes at or above
// FONT_GLYPHS draw as background. Font bytes never loaded read as garbage.
// A printable character keeps the sequencer busy for its command and rows,
// paced by the single font read port that delivers one 16-bit glyph row per
// cycle unless the result channel stalls. Results sit in a two-entry
// pipeline (read stage plus output register), so the next request
// is taken while earlier rows still wait on a stalled result channel.
// CSR writes (index 0 width, 1 height, 2 foreground, 3 background) must only
// be made while the block is idle. The font store has no reset or clearing pass.
module text_console_glyph_renderer_core #(
   parameter int FONT_GLYPHS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   tcg_req_if.sink     req_if,
   tcg_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tcg_pkg::*;

   // configuration registers
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [31:0] fore_ff, fore_in;
   logic [31:0] back_ff, back_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      fore_in   = fore_ff;
      back_in   = back_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata[12:0];
            CSR_SCREEN_HEIGHT: height_in = csr_wdata[12:0];
            CSR_FORE_COLOR:    fore_in   = csr_wdata;
            CSR_BACK_COLOR:    back_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1024;
         height_ff <= 13'd768;
         fore_ff   <= 32'h00ff_ffff;
         back_ff   <= 32'h0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         fore_ff   <= fore_in;
         back_ff   <= back_in;
      end
   end

   // sequencer <-> font store <-> output pipeline
   logic       issue;
   logic       issue_ready;
   tok_type    tok;
   rdreq_type  rd;
   wrreq_type  wr;
   logic [7:0] rd_lo;
   logic [7:0] rd_hi;

   tcg_ctrl #(
      .FONT_GLYPHS (FONT_GLYPHS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .issue_ready   (issue_ready),
      .issue         (issue),
      .tok           (tok),
      .rd            (rd),
      .wr            (wr)
   );

   tcg_font_mem #(
      .FONT_GLYPHS (FONT_GLYPHS)
   ) u_font_mem (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rd_lo (rd_lo),
      .rd_hi (rd_hi)
   );

   tcg_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .tok         (tok),
      .rd_lo       (rd_lo),
      .rd_hi       (rd_hi),
      .fore_color  (fore_ff),
      .back_color  (back_ff),
      .issue_ready (issue_ready),
      .rsp         (rsp_if)
   );

   // commands carry nothing but their kind
   a_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind != KIND_GLYPH |->
         rsp_if.row_mask == 16'h0 && rsp_if.last == 1'b0 && rsp_if.pixel_count == 5'd0 &&
         rsp_if.fore_color == 32'h0 && rsp_if.back_color == 32'h0)
      else $error("command result with nonzero fields");

   a_glyph_width: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == KIND_GLYPH |->
         rsp_if.pixel_count == WIDTH_NARROW || rsp_if.pixel_count == WIDTH_WIDE)
      else $error("glyph row with bad pixel count");

   // a printable character occupies the sequencer after its transfer
   a_busy_after_char: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.opcode == OP_PUT &&
      req_if.char_code != CODE_NEWLINE && req_if.char_code != CODE_CR |=> !req_if.ready)
      else $error("request taken while rendering");

endmodule

// ===== rtl/tcg_font_mem.sv =====
module tcg_font_mem #(
   parameter int FONT_GLYPHS = 4096
) (
   input  logic               clock,
   input  tcg_pkg::wrreq_type wr,
   input  tcg_pkg::rdreq_type rd,
   output logic [7:0]         rd_lo,
   output logic [7:0]         rd_hi
);
   import tcg_pkg::*;

   localparam int Depth      = FONT_GLYPHS * 16;
   localparam int AW         = $clog2(Depth);
   localparam int StoreBytes = FONT_GLYPHS * 32;

   // left byte and right byte of each glyph row
   logic [7:0] lo_mem [Depth];
   logic [7:0] hi_mem [Depth];

   logic [7:0] rd_lo_ff;
   logic [7:0] rd_hi_ff;

   logic          wr_ok;
   logic [AW-1:0] wr_idx;
   logic [AW-1:0] rd_idx;

   assign wr_ok  = wr.en && ({15'b0, wr.addr} < 32'(StoreBytes));
   assign wr_idx = AW'(wr.addr >> 1);
   assign rd_idx = AW'({rd.code, rd.row});

   always_ff @(posedge clock) begin
      if (wr_ok && !wr.addr[0]) begin
         lo_mem[wr_idx] <= wr.data;
      end
      if (wr_ok && wr.addr[0]) begin
         hi_mem[wr_idx] <= wr.data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_lo_ff <= lo_mem[rd_idx];
         rd_hi_ff <= hi_mem[rd_idx];
      end
   end

   assign rd_lo = rd_lo_ff;
   assign rd_hi = rd_hi_ff;

endmodule

// ===== rtl/tcg_ctrl.sv =====
module tcg_ctrl #(
   parameter int FONT_GLYPHS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   tcg_req_if.sink            req,
   input  logic [12:0]        screen_width,
   input  logic [12:0]        screen_height,
   input  logic               issue_ready,
   output logic               issue,
   output tcg_pkg::tok_type   tok,
   output tcg_pkg::rdreq_type rd,
   output tcg_pkg::wrreq_type wr
);
   import tcg_pkg::*;

   localparam logic [16:0] GlyphLimit = 17'(FONT_GLYPHS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMD  = 2'd1;
   localparam logic [1:0] ST_ROWS = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  row_idx_ff, row_idx_in;
   logic [11:0] cur_col_ff, cur_col_in;
   logic [12:0] cur_row_ff, cur_row_in;
   logic [11:0] base_col_ff, base_col_in;
   logic [12:0] base_row_ff, base_row_in;
   logic [15:0] code_ff, code_in;
   logic        wide_ff, wide_in;
   logic        glyph_ok_ff, glyph_ok_in;
   kind_type    cmd_kind_ff, cmd_kind_in;

   logic        acc;
   logic        is_nl, is_cr, is_glyph;
   logic        wide;
   logic [4:0]  fw;
   logic        bottom, tall, wrap;
   logic [12:0] row1, row2;
   logic [11:0] col2;
   logic [13:0] wsum;
   logic [12:0] csum;

   assign req.ready = (state_ff == ST_IDLE);
   assign acc       = req.valid && req.ready;
   assign is_nl     = acc && req.opcode == OP_PUT && req.char_code == CODE_NEWLINE;
   assign is_cr     = acc && req.opcode == OP_PUT && req.char_code == CODE_CR;
   assign is_glyph  = acc && req.opcode == OP_PUT && !is_nl && !is_cr;

   assign wr.en   = acc && req.opcode == OP_LOAD;
   assign wr.addr = req.font_address;
   assign wr.data = req.font_byte;

   // scroll / clear decision, then line wrap, on the cursor as it stands
   assign wide   = req.char_code > NARROW_MAX;
   assign fw     = wide ? WIDTH_WIDE : WIDTH_NARROW;
   assign bottom = screen_height <= cur_row_ff;
   assign tall   = screen_height >= 13'(LINE_HEIGHT);
   assign row1   = (bottom && tall) ? cur_row_ff - 13'(LINE_HEIGHT) : cur_row_ff;
   assign wsum   = {2'b0, cur_col_ff} + {9'b0, fw};
   assign wrap   = wsum > {1'b0, screen_width};
   assign row2   = wrap ? row_add(row1, LINE_HEIGHT) : row1;
   assign col2   = wrap ? '0 : cur_col_ff;
   assign csum   = {1'b0, col2} + {8'b0, fw};

   always_comb begin
      state_in    = state_ff;
      row_idx_in  = row_idx_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      base_col_in = base_col_ff;
      base_row_in = base_row_ff;
      code_in     = code_ff;
      wide_in     = wide_ff;
      glyph_ok_in = glyph_ok_ff;
      cmd_kind_in = cmd_kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_nl) begin
               cur_row_in = row_add(cur_row_ff, LINE_HEIGHT);
               cur_col_in = '0;
            end
            if (is_cr) begin
               cur_col_in = (cur_col_ff >= 12'(WIDTH_NARROW)) ?
                            cur_col_ff - 12'(WIDTH_NARROW) : '0;
            end
            if (is_glyph) begin
               state_in    = bottom ? ST_CMD : ST_ROWS;
               row_idx_in  = '0;
               cmd_kind_in = tall ? KIND_SCROLL : KIND_CLEAR;
               base_col_in = col2;
               base_row_in = row2;
               code_in     = req.char_code;
               wide_in     = wide;
               glyph_ok_in = {1'b0, req.char_code} < GlyphLimit;
               cur_row_in  = row2;
               cur_col_in  = csum[12] ? COL_MAX : csum[11:0];
            end
         end
         ST_CMD: begin
            if (issue_ready) begin
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (issue_ready) begin
               row_idx_in = row_idx_ff + 4'd1;
               if (row_idx_ff == LAST_ROW) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_idx_ff <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         row_idx_ff <= row_idx_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

   always_ff @(posedge clock) begin
      base_col_ff <= base_col_in;
      base_row_ff <= base_row_in;
      code_ff     <= code_in;
      wide_ff     <= wide_in;
      glyph_ok_ff <= glyph_ok_in;
      cmd_kind_ff <= cmd_kind_in;
   end

   assign issue = (state_ff != ST_IDLE) && issue_ready;

   always_comb begin
      tok = '0;
      if (state_ff == ST_CMD) begin
         tok.kind = cmd_kind_ff;
      end else begin
         tok.kind     = KIND_GLYPH;
         tok.pixel_x  = base_col_ff;
         tok.pixel_y  = row_add(base_row_ff, {1'b0, row_idx_ff});
         tok.wide     = wide_ff;
         tok.glyph_ok = glyph_ok_ff;
         tok.last     = (row_idx_ff == LAST_ROW);
      end
   end

   assign rd.en   = issue;
   assign rd.code = glyph_ok_ff ? code_ff : '0;
   assign rd.row  = row_idx_ff;

endmodule

// ===== rtl/tcg_out_stage.sv =====
module tcg_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             issue,
   input  tcg_pkg::tok_type tok,
   input  logic [7:0]       rd_lo,
   input  logic [7:0]       rd_hi,
   input  logic [31:0]      fore_color,
   input  logic [31:0]      back_color,
   output logic             issue_ready,
   tcg_rsp_if.source        rsp
);
   import tcg_pkg::*;

   // stage b: token aligned with font read data
   logic        b_valid_ff, b_valid_in;
   tok_type     b_tok_ff, b_tok_in;
   logic        b_move;

   // stage c: output register
   logic        c_valid_ff, c_valid_in;
   kind_type    c_kind_ff, c_kind_in;
   logic [11:0] c_x_ff, c_x_in;
   logic [12:0] c_y_ff, c_y_in;
   logic [4:0]  c_count_ff, c_count_in;
   logic [15:0] c_mask_ff, c_mask_in;
   logic [31:0] c_fore_ff, c_fore_in;
   logic [31:0] c_back_ff, c_back_in;
   logic        c_last_ff, c_last_in;

   logic        is_glyph;
   logic [15:0] mask;

   assign b_move      = b_valid_ff && (!c_valid_ff || rsp.ready);
   assign issue_ready = !b_valid_ff || b_move;
   assign b_valid_in  = issue || (b_valid_ff && !b_move);
   assign b_tok_in    = issue ? tok : b_tok_ff;

   assign is_glyph = (b_tok_ff.kind == KIND_GLYPH);

   always_comb begin
      mask = '0;
      if (is_glyph && b_tok_ff.glyph_ok) begin
         mask[7:0] = flip8(rd_lo);
         if (b_tok_ff.wide) begin
            mask[15:8] = flip8(rd_hi);
         end
      end
   end

   always_comb begin
      c_valid_in = b_move || (c_valid_ff && !rsp.ready);
      c_kind_in  = c_kind_ff;
      c_x_in     = c_x_ff;
      c_y_in     = c_y_ff;
      c_count_in = c_count_ff;
      c_mask_in  = c_mask_ff;
      c_fore_in  = c_fore_ff;
      c_back_in  = c_back_ff;
      c_last_in  = c_last_ff;
      if (b_move) begin
         c_kind_in  = b_tok_ff.kind;
         c_x_in     = b_tok_ff.pixel_x;
         c_y_in     = b_tok_ff.pixel_y;
         c_count_in = !is_glyph ? '0 : (b_tok_ff.wide ? WIDTH_WIDE : WIDTH_NARROW);
         c_mask_in  = mask;
         c_fore_in  = is_glyph ? fore_color : '0;
         c_back_in  = is_glyph ? back_color : '0;
         c_last_in  = b_tok_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_tok_ff   <= b_tok_in;
      c_kind_ff  <= c_kind_in;
      c_x_ff     <= c_x_in;
      c_y_ff     <= c_y_in;
      c_count_ff <= c_count_in;
      c_mask_ff  <= c_mask_in;
      c_fore_ff  <= c_fore_in;
      c_back_ff  <= c_back_in;
      c_last_ff  <= c_last_in;
   end

   assign rsp.valid       = c_valid_ff;
   assign rsp.kind        = c_kind_ff;
   assign rsp.pixel_x     = c_x_ff;
   assign rsp.pixel_y     = c_y_ff;
   assign rsp.pixel_count = c_count_ff;
   assign rsp.row_mask    = c_mask_ff;
   assign rsp.fore_color  = c_fore_ff;
   assign rsp.back_color  = c_back_ff;
   assign rsp.last        = c_last_ff;

endmodule
